// ===== rtl/core/serial_frame_deframer_checksum_unit_assert.svh =====
// Assertion macros for the checker file of the frame deframer
`ifndef SERIAL_FRAME_DEFRAMER_CHECKSUM_UNIT_ASSERT_SVH
`define SERIAL_FRAME_DEFRAMER_CHECKSUM_UNIT_ASSERT_SVH

// same-cycle implication, clocked on clk, quiet while rst is high
`define SFDC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sfdc assertion failed");

// next-cycle implication, clocked on clk, quiet while rst is high
`define SFDC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sfdc assertion failed");

`endif

// ===== rtl/core/sfdc_pkg.sv =====
// Package: constants, status codes and result types of the frame deframer
package sfdc_pkg;

  localparam logic [7:0] HDR_FIRST   = 8'hAA;
  localparam logic [7:0] HDR_SECOND  = 8'hFF;
  localparam logic [7:0] TAIL_RESET  = 8'hED;
  localparam logic [7:0] LEN_NONE    = 8'h00;

  // body positions
  localparam logic [3:0] POS_LEN_LOW     = 4'd4;
  localparam logic [3:0] TAIL_WITH_VALUE = 4'd8;
  localparam logic [3:0] TAIL_NO_VALUE   = 4'd7;
  localparam int         FIELD_SLOTS     = 7;
  localparam logic [3:0] FIELD_LIMIT     = 4'(FIELD_SLOTS);

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_TAIL = 2'd1,
    ST_BAD_SUM  = 2'd2
  } frame_status_t;

  typedef struct packed {
    logic [7:0]    seq_num;
    logic [7:0]    category;
    logic [7:0]    msg_type;
    logic [7:0]    msg_flag;
    logic [7:0]    len_low;
    logic [7:0]    len_high;
    logic          has_value;
    logic [7:0]    value_byte;
    frame_status_t frame_status;
  } frame_result_t;

  // tracker to output stage
  typedef struct packed {
    logic          fire;
    frame_result_t res;
  } trk_out_t;

endpackage

// ===== rtl/core/sfdc_rx_if.sv =====
// Interface: received byte channel
interface sfdc_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/core/sfdc_frame_if.sv =====
// Interface: decoded frame result channel
interface sfdc_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] seq_num;
  logic [7:0] category;
  logic [7:0] msg_type;
  logic [7:0] msg_flag;
  logic [7:0] len_low;
  logic [7:0] len_high;
  logic       has_value;
  logic [7:0] value_byte;
  logic [1:0] frame_status;

  modport source (
    output valid, output seq_num, output category, output msg_type, output msg_flag,
    output len_low, output len_high, output has_value, output value_byte,
    output frame_status, input ready
  );
  modport sink (
    input valid, input seq_num, input category, input msg_type, input msg_flag,
    input len_low, input len_high, input has_value, input value_byte,
    input frame_status, output ready
  );
endinterface

// ===== rtl/core/sfdc_track.sv =====
// Header hunt, body capture and running checksum of the frame deframer
module sfdc_track (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        tail_value,
  input  logic              out_busy,
  sfdc_rx_if.sink           rx,
  output sfdc_pkg::trk_out_t trk
);
  import sfdc_pkg::*;

  logic              in_frame;
  logic              hdr_seen;
  logic [3:0]        pos;
  logic              has_value;
  logic [7:0]        sum;
  logic [7:0]        prev;
  logic [7:0]        body [FIELD_SLOTS];

  logic              at_tail;
  logic              accept;
  logic [7:0]        b;
  logic [7:0]        body_sum;
  frame_status_t     status;

  assign b       = rx.rx_byte;
  assign at_tail = in_frame && (pos == (has_value ? TAIL_WITH_VALUE : TAIL_NO_VALUE));
  // only a tail word needs room in the output register
  assign rx.ready = !(at_tail && out_busy);
  assign accept   = rx.valid && rx.ready;

  // sum covers bytes up to the checksum; drop the checksum itself
  assign body_sum = sum - prev;

  always_comb begin
    if (b != tail_value) begin
      status = ST_BAD_TAIL;
    end else if (body_sum != prev) begin
      status = ST_BAD_SUM;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    trk.fire             = accept && at_tail;
    trk.res.seq_num      = body[0];
    trk.res.category     = body[1];
    trk.res.msg_type     = body[2];
    trk.res.msg_flag     = body[3];
    trk.res.len_low      = body[4];
    trk.res.len_high     = body[5];
    trk.res.has_value    = has_value;
    trk.res.value_byte   = has_value ? body[6] : 8'h00;
    trk.res.frame_status = status;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame  <= 1'b0;
      hdr_seen  <= 1'b0;
      pos       <= '0;
      has_value <= 1'b1;
    end else if (accept) begin
      if (!in_frame) begin
        if (b == HDR_FIRST) begin
          hdr_seen <= 1'b1;
        end else if (b == HDR_SECOND && hdr_seen) begin
          in_frame  <= 1'b1;
          hdr_seen  <= 1'b0;
          pos       <= '0;
          has_value <= 1'b1;
        end else begin
          hdr_seen <= 1'b0;
        end
      end else begin
        if (pos == POS_LEN_LOW && b == LEN_NONE) begin
          has_value <= 1'b0;
        end
        if (at_tail) begin
          in_frame <= 1'b0;
          pos      <= '0;
        end else begin
          pos <= pos + 4'd1;
        end
      end
    end
  end

  // body capture and running sum
  always_ff @(posedge clk) begin
    if (accept) begin
      if (!in_frame) begin
        sum <= 8'h00;
      end else begin
        sum  <= sum + b;
        prev <= b;
        if (pos < FIELD_LIMIT) begin
          body[pos[2:0]] <= b;
        end
      end
    end
  end

endmodule

// ===== rtl/core/sfdc_out.sv =====
// Result register driving the frame channel
module sfdc_out (
  input  logic               clk,
  input  logic               rst,
  input  sfdc_pkg::trk_out_t trk,
  output logic               busy,
  sfdc_frame_if.source       frame
);
  import sfdc_pkg::*;

  logic          valid;
  frame_result_t res;

  assign busy = valid && !frame.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!busy) begin
      valid <= trk.fire;
    end
  end

  // payload loads only on a new result
  always_ff @(posedge clk) begin
    if (!busy && trk.fire) begin
      res <= trk.res;
    end
  end

  assign frame.valid        = valid;
  assign frame.seq_num      = res.seq_num;
  assign frame.category     = res.category;
  assign frame.msg_type     = res.msg_type;
  assign frame.msg_flag     = res.msg_flag;
  assign frame.len_low      = res.len_low;
  assign frame.len_high     = res.len_high;
  assign frame.has_value    = res.has_value;
  assign frame.value_byte   = res.value_byte;
  assign frame.frame_status = res.frame_status;

endmodule

// ===== rtl/core/serial_frame_deframer_checksum_unit.sv =====
// A result is registered and shown in the cycle after its tail word is accepted.
// Throughput: one word per cycle; the checksum is summed as the body arrives.
// The receive side stalls only when a tail word meets a result still waiting,
// set by the single output register.
// Reset (rst, synchronous): hunting for the header, no result, tail value 0xED.
module serial_frame_deframer_checksum_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [7:0]   cfg_wr_data,
  sfdc_rx_if.sink      rx,
  sfdc_frame_if.source frame
);
  import sfdc_pkg::*;

  logic [7:0] tail_value;
  logic       out_busy;
  trk_out_t   trk;

  // expected tail register
  always_ff @(posedge clk) begin
    if (rst) begin
      tail_value <= TAIL_RESET;
    end else if (cfg_wr_en) begin
      tail_value <= cfg_wr_data;
    end
  end

  sfdc_track u_track (
    .clk        (clk),
    .rst        (rst),
    .tail_value (tail_value),
    .out_busy   (out_busy),
    .rx         (rx),
    .trk        (trk)
  );

  sfdc_out u_out (
    .clk   (clk),
    .rst   (rst),
    .trk   (trk),
    .busy  (out_busy),
    .frame (frame)
  );

endmodule

// ===== rtl/core/sfdc_checker.sv =====
// Port-level checker for the frame deframer, bound to the top level
`include "serial_frame_deframer_checksum_unit_assert.svh"

module sfdc_checker (
  input logic       clk,
  input logic       rst,
  input logic       rx_valid,
  input logic       rx_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] seq_num,
  input logic [7:0] len_low,
  input logic       has_value,
  input logic [7:0] value_byte,
  input logic [1:0] frame_status
);

  // a stalled result holds
  `SFDC_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(seq_num) && $stable(len_low) && $stable(value_byte) && $stable(frame_status))

  // absent value reads as zero
  `SFDC_ASSERT_NOW(a_no_value, out_valid && !has_value, value_byte == 8'h00)

  // a new result follows an accepted word
  `SFDC_ASSERT_NOW(a_cause, $rose(out_valid), $past(rx_valid && rx_ready))

  // with the output register empty no word is refused
  `SFDC_ASSERT_NOW(a_ready, !out_valid, rx_ready)

endmodule

bind serial_frame_deframer_checksum_unit sfdc_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .rx_valid     (rx.valid),
  .rx_ready     (rx.ready),
  .out_valid    (frame.valid),
  .out_ready    (frame.ready),
  .seq_num      (frame.seq_num),
  .len_low      (frame.len_low),
  .has_value    (frame.has_value),
  .value_byte   (frame.value_byte),
  .frame_status (frame.frame_status)
);
